### design/knps_pkg.sv
// Shared types, sizes and the ranking function for the k nearest points selector.
// Used by knps_cell and k_nearest_points_select_core; depends on nothing else.
`default_nettype none

package knps_pkg;

  localparam int MAX_KEEP   = 16;
  localparam int COORD_BITS = 16;
  localparam int DIST_W     = 2 * COORD_BITS;
  localparam int KCFG_W     = 5;
  localparam int CNT_W      = $clog2(MAX_KEEP + 1);
  localparam int KCMP_W     = (CNT_W > KCFG_W) ? CNT_W : KCFG_W;

  // Every cell but the top one of the chain.
  localparam logic [MAX_KEEP-1:0] LOW_CELLS = {MAX_KEEP{1'b1}} >> 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [DIST_W-1:0]            dist_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    dist_t  d;
  } point_t;

  typedef struct packed {
    logic insert;  // a new point enters the sorted chain
    logic shift;   // flush: every cell takes its lower neighbor
    logic keep;    // this cell lies below the current k
  } cell_ctrl_t;

  // True when a ranks strictly below b by (distance, x, y).
  function automatic logic key_less(input point_t a, input point_t b);
    logic res;
    if (a.d != b.d) begin
      res = (a.d < b.d);
    end else if (a.x != b.x) begin
      res = ($signed(a.x) < $signed(b.x));
    end else begin
      res = ($signed(a.y) < $signed(b.y));
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### design/knps_cell.sv
// One cell of the sorted insertion chain: holds one kept point and its valid bit.
// Depends on knps_pkg for the point type, the control struct and key_less.
`default_nettype none

module knps_cell (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire knps_pkg::cell_ctrl_t ctrl,
  input  wire knps_pkg::point_t    new_pt,
  input  wire knps_pkg::point_t    prev_pt,
  input  wire logic                prev_vld,
  input  wire logic                prev_less,
  output knps_pkg::point_t         pt,
  output logic                     vld,
  output logic                     less
);
  import knps_pkg::*;

  point_t pt_r, pt_nxt;
  logic   vld_r, vld_nxt;

  // An empty cell ranks above every point.
  assign less = !vld_r || key_less(new_pt, pt_r);

  always_comb begin
    pt_nxt  = pt_r;
    vld_nxt = vld_r;
    if (ctrl.shift) begin
      pt_nxt  = prev_pt;
      vld_nxt = prev_vld;
    end else if (ctrl.insert) begin
      if (less) begin
        if (prev_less) begin
          pt_nxt  = prev_pt;
          vld_nxt = prev_vld;
        end else begin
          pt_nxt  = new_pt;
          vld_nxt = 1'b1;
        end
      end
      vld_nxt = vld_nxt && ctrl.keep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pt_r <= pt_nxt;
  end

  assign pt  = pt_r;
  assign vld = vld_r;

endmodule

`default_nettype wire

### design/k_nearest_points_select_core.sv
// Top level of the k nearest points selector: input and square stage, the chain of
// sorted cells, the flush control and the output register. Depends on knps_pkg, knps_cell.
//
// Usage. Points arrive on the in_ channel (in_valid / in_stall) with signed x and y and
// an end_of_set flag. A transfer happens at a rising edge with valid high and stall low.
// The block keeps the k points with the smallest key (squared distance, x, y); k comes
// from cfg_wdata, written whenever cfg_we is high, and is read as 1 for zero and as
// MAX_KEEP above that. Write it only while the block is idle.
// Each point is registered in the square stage and then placed in the sorted chain; a
// new point may follow every cycle, so the rate is one point a cycle outside flushes.
// A point with end_of_set is stored like any other and then starts a flush: the chain
// shifts upward by one cell a cycle unless an out_ stall holds it, and the top cell is
// handed to the output register. Results leave largest key first on the out_ channel,
// the last one with out_final_result set, and the store is empty afterwards. Once the
// first result appears, one result leaves per cycle while the receiver does not stall.
// While a flush runs the input channel stalls once its one waiting point is taken. A
// stall on the out_ channel holds a waiting result in the output register and, once the
// top cell is occupied, freezes the chain until the result is taken.
// Reset (rst_n low at a clock edge) empties the store, drops any pending point or
// result, and sets k to 1.
`default_nettype none

module k_nearest_points_select_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [knps_pkg::KCFG_W-1:0]  cfg_wdata,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [knps_pkg::COORD_BITS-1:0] in_point_x,
  input  wire logic signed [knps_pkg::COORD_BITS-1:0] in_point_y,
  input  wire logic                         in_end_of_set,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [knps_pkg::COORD_BITS-1:0] out_x,
  output logic signed [knps_pkg::COORD_BITS-1:0] out_y,
  output logic [knps_pkg::DIST_W-1:0]       out_squared_distance,
  output logic                              out_final_result
);
  import knps_pkg::*;

  // Which cells lie below k; rewritten on every configuration write.
  logic [MAX_KEEP-1:0] keep_mask_r, keep_mask_nxt;
  logic [KCMP_W-1:0]   cfg_ext, eff_k;

  always_comb begin
    cfg_ext = KCMP_W'(cfg_wdata);
    if (cfg_ext == '0) begin
      eff_k = KCMP_W'(1);
    end else if (cfg_ext > KCMP_W'(MAX_KEEP)) begin
      eff_k = KCMP_W'(MAX_KEEP);
    end else begin
      eff_k = cfg_ext;
    end
    for (int i = 0; i < MAX_KEEP; i++) begin
      keep_mask_nxt[i] = (KCMP_W'(i) < eff_k);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_mask_r <= MAX_KEEP'(1);
    end else if (cfg_we) begin
      keep_mask_r <= keep_mask_nxt;
    end
  end

  // Square stage: the two squares are registered here and summed in the insert cycle.
  logic   s1_vld_r, s1_vld_nxt;
  coord_t s1_x_r, s1_y_r;
  dist_t  s1_sqx_r, s1_sqy_r;
  logic   s1_eos_r;
  logic signed [DIST_W-1:0] sqx, sqy;
  logic   in_fire, insert_go;
  logic   flush_r, flush_nxt;

  assign in_stall  = s1_vld_r && flush_r;
  assign in_fire   = in_valid && !in_stall;
  assign insert_go = s1_vld_r && !flush_r;

  assign sqx = DIST_W'(in_point_x) * DIST_W'(in_point_x);
  assign sqy = DIST_W'(in_point_y) * DIST_W'(in_point_y);

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_fire) begin
      s1_vld_nxt = 1'b1;
    end else if (insert_go) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_x_r   <= in_point_x;
      s1_y_r   <= in_point_y;
      s1_sqx_r <= dist_t'(sqx);
      s1_sqy_r <= dist_t'(sqy);
      s1_eos_r <= in_end_of_set;
    end
  end

  point_t new_pt;
  assign new_pt.x = s1_x_r;
  assign new_pt.y = s1_y_r;
  assign new_pt.d = s1_sqx_r + s1_sqy_r;

  // Chain of cells, cell 0 holding the smallest key. In a flush the chain shifts
  // toward the top cell, which feeds the output register.
  point_t              cell_pt [MAX_KEEP];
  logic [MAX_KEEP-1:0] cell_vld;
  logic [MAX_KEEP-1:0] cell_less;
  logic                top_vld, out_load, shift_en, last_pt;

  assign top_vld  = cell_vld[MAX_KEEP-1];
  assign out_load = flush_r && top_vld && (!out_valid || !out_stall);
  assign shift_en = flush_r && (!top_vld || out_load);
  // The occupied cells form one unbroken run, so the top one is the last when no
  // other cell is occupied.
  assign last_pt  = ((cell_vld & LOW_CELLS) == '0);

  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    cell_ctrl_t ctrl;
    point_t     prev_pt;
    logic       prev_vld, prev_less;

    assign ctrl.insert = insert_go;
    assign ctrl.shift  = shift_en;
    assign ctrl.keep   = keep_mask_r[i];

    if (i == 0) begin : g_first
      assign prev_pt   = new_pt;
      assign prev_vld  = 1'b0;
      assign prev_less = 1'b0;
    end else begin : g_next
      assign prev_pt   = cell_pt[i-1];
      assign prev_vld  = cell_vld[i-1];
      assign prev_less = cell_less[i-1];
    end

    knps_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .new_pt   (new_pt),
      .prev_pt  (prev_pt),
      .prev_vld (prev_vld),
      .prev_less(prev_less),
      .pt       (cell_pt[i]),
      .vld      (cell_vld[i]),
      .less     (cell_less[i])
    );
  end

  // Flush control: starts when a point with end_of_set has been stored, ends when the
  // last point leaves the chain.
  always_comb begin
    flush_nxt = flush_r;
    if (insert_go && s1_eos_r) begin
      flush_nxt = 1'b1;
    end else if (out_load && last_pt) begin
      flush_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flush_r <= 1'b0;
    end else begin
      flush_r <= flush_nxt;
    end
  end

  // Output register.
  logic out_valid_r, out_valid_nxt;
  point_t out_pt_r;
  logic out_final_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pt_r    <= cell_pt[MAX_KEEP-1];
      out_final_r <= last_pt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_x                = out_pt_r.x;
  assign out_y                = out_pt_r.y;
  assign out_squared_distance = out_pt_r.d;
  assign out_final_result     = out_final_r;

endmodule

`default_nettype wire

### dv/k_nearest_points_select_core_test.sv
// Self-checking testbench for the k nearest points selector core.
// Depends on knps_pkg and k_nearest_points_select_core from the design folder.
`default_nettype none

module k_nearest_points_select_core_test;
  import knps_pkg::*;

  // One point as it should leave the block during a flush.
  typedef struct packed {
    coord_t x;
    coord_t y;
    dist_t  d;
    logic   last;
  } flushed_point_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [KCFG_W-1:0]   cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  coord_t              in_point_x = '0;
  coord_t              in_point_y = '0;
  logic                in_end_of_set = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  coord_t              out_x;
  coord_t              out_y;
  dist_t               out_squared_distance;
  logic                out_final_result;

  // Our own copy of the sorted store, ascending by (distance, x, y).
  point_t              held[MAX_KEEP+1];
  int                  held_count = 0;
  logic [KCFG_W-1:0]   keep_reg = KCFG_W'(1);

  // Points that a flush has released and that the out_ channel still owes us.
  flushed_point_t      pending_results[$];
  flushed_point_t      oldest;

  int                  fail_count = 0;
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  int                  hold_left = 0;

  k_nearest_points_select_core DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_point_x           (in_point_x),
    .in_point_y           (in_point_y),
    .in_end_of_set        (in_end_of_set),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_x                (out_x),
    .out_y                (out_y),
    .out_squared_distance (out_squared_distance),
    .out_final_result     (out_final_result)
  );

  always #5 clk = ~clk;

  // The run is bounded by a fixed time well beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("FAIL k_nearest_points_select_core");
    $finish;
  end

  // x squared plus y squared; the widest case, both coordinates at the most
  // negative value, is exactly 2**31 and still fits the 32-bit field.
  function automatic dist_t square_sum(input coord_t x, input coord_t y);
    longint sx;
    longint sy;
    sx = x;
    sy = y;
    return dist_t'(sx * sx + sy * sy);
  endfunction

  // Ranking by (distance, x, y). Flipping the sign bits of the coordinates
  // turns the signed order into a plain unsigned order of one wide vector.
  function automatic logic ranks_below(input point_t a, input point_t b);
    logic [DIST_W+2*COORD_BITS-1:0] ka;
    logic [DIST_W+2*COORD_BITS-1:0] kb;
    ka = {a.d, ~a.x[COORD_BITS-1], a.x[COORD_BITS-2:0], ~a.y[COORD_BITS-1], a.y[COORD_BITS-2:0]};
    kb = {b.d, ~b.x[COORD_BITS-1], b.x[COORD_BITS-2:0], ~b.y[COORD_BITS-1], b.y[COORD_BITS-2:0]};
    return ka < kb;
  endfunction

  // The register value as the block reads it: zero counts as one, anything
  // above the store size counts as the store size.
  function automatic int kept_limit();
    int lim;
    lim = keep_reg;
    if (lim == 0) begin
      lim = 1;
    end else if (lim > MAX_KEEP) begin
      lim = MAX_KEEP;
    end
    return lim;
  endfunction

  // Applies one transferred point to the store copy. The point is inserted
  // first, then the store is cut back to k, so a lowered k drops several
  // points at once. An end-of-set point then releases the whole store,
  // largest key first.
  task automatic store_point(input coord_t x, input coord_t y, input logic eos);
    point_t         p;
    flushed_point_t owed;
    int             pos;
    int             i;
    p.x = x;
    p.y = y;
    p.d = square_sum(x, y);
    pos = 0;
    while (pos < held_count && !ranks_below(p, held[pos])) pos++;
    for (i = held_count; i > pos; i--) held[i] = held[i-1];
    held[pos] = p;
    held_count++;
    if (held_count > kept_limit()) held_count = kept_limit();
    if (eos) begin
      for (i = held_count - 1; i >= 0; i--) begin
        owed = '{held[i].x, held[i].y, held[i].d, (i == 0)};
        pending_results = {pending_results, owed};
      end
      held_count = 0;
    end
  endtask

  // Offers one point on the in_ channel. Valid is only lowered when the sender
  // decides to idle, so back-to-back points keep valid high without a glitch.
  task automatic offer_point(input coord_t x, input coord_t y, input logic eos);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_point_x    <= x;
    in_point_y    <= y;
    in_end_of_set <= eos;
    do @(posedge clk); while (in_stall);
    store_point(x, y, eos);
  endtask

  // Writes k with the block idle: no point on the way in, every released point
  // taken, and enough cycles after that for a point without a flush to settle
  // into the chain.
  task automatic write_keep_count(input logic [KCFG_W-1:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (MAX_KEEP + 4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    keep_reg  = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Receiver side: a long hold when asked for, random stalls otherwise.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Every transfer on the out_ channel is matched against the oldest point
  // still owed.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing owed: x %0d y %0d", out_x, out_y);
        fail_count++;
      end else begin
        oldest = pending_results.pop_front();
        if (out_x !== oldest.x) begin
          $error("out_x: expected %0d, got %0d", oldest.x, out_x);
          fail_count++;
        end
        if (out_y !== oldest.y) begin
          $error("out_y: expected %0d, got %0d", oldest.y, out_y);
          fail_count++;
        end
        if (out_squared_distance !== oldest.d) begin
          $error("out_squared_distance: expected %0d, got %0d", oldest.d,
                 out_squared_distance);
          fail_count++;
        end
        if (out_final_result !== oldest.last) begin
          $error("out_final_result: expected %0d, got %0d", oldest.last,
                 out_final_result);
          fail_count++;
        end
      end
    end
  end

  // A coordinate from one of several ranges: the full range, a narrow band
  // around zero that makes equal distances common, or the corner values.
  function automatic coord_t pick_coord(input int style);
    coord_t c;
    case (style)
      0: begin
        c = coord_t'($urandom);
      end
      1: begin
        c = coord_t'($urandom_range(8)) - coord_t'(4);
      end
      default: begin
        case ($urandom_range(4))
          0: c = 16'sh8000;
          1: c = 16'sh7fff;
          2: c = '0;
          3: c = -16'sd1;
          default: c = 16'sd1;
        endcase
      end
    endcase
    return c;
  endfunction

  // Whole sets with random content. Most sets are short; now and then one has 12 to
  // 24 points and so can be longer than the store, so that points really get dropped.
  task automatic run_random_sets(input int item_total);
    int     sent;
    int     len;
    int     j;
    int     pick;
    coord_t x;
    coord_t y;
    sent = 0;
    x = '0;
    y = '0;
    while (sent < item_total) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 8);
      for (j = 0; j < len; j++) begin
        pick = $urandom_range(9);
        // A repeat of the previous point gives keys that tie completely.
        if (!(pick == 9 && j > 0)) begin
          x = pick_coord(pick < 4 ? 0 : (pick < 7 ? 1 : 2));
          y = pick_coord(pick < 4 ? 0 : (pick < 7 ? 1 : 2));
        end
        offer_point(x, y, (j == len - 1));
      end
      sent += len;
    end
  endtask

  // Corner coordinates, equal distances with different x and y, and two
  // identical points, all in one set with the largest k.
  task automatic test_extremes();
    send_idle_pct = 20;
    recv_idle_pct = 56;
    write_keep_count(5'd31);
    offer_point(16'sh8000, 16'sh8000, 1'b0);
    offer_point(16'sh7fff, 16'sh7fff, 1'b0);
    offer_point(16'sh8000, 16'sh7fff, 1'b0);
    offer_point(16'sd0, 16'sd0, 1'b0);
    offer_point(16'sd5, 16'sd0, 1'b0);
    offer_point(16'sd0, 16'sd5, 1'b0);
    offer_point(-16'sd5, 16'sd0, 1'b0);
    offer_point(16'sd0, -16'sd5, 1'b0);
    offer_point(16'sd3, 16'sd4, 1'b0);
    offer_point(-16'sd4, 16'sd3, 1'b0);
    offer_point(16'sd1, 16'sd1, 1'b0);
    offer_point(16'sd1, 16'sd1, 1'b0);
    offer_point(-16'sd1, -16'sd1, 1'b1);
  endtask

  // k written as zero keeps one point; a set of a single point flushes alone.
  task automatic test_keep_limits();
    write_keep_count(5'd0);
    offer_point(16'sd7, 16'sd7, 1'b0);
    offer_point(16'sd2, -16'sd2, 1'b0);
    offer_point(16'sd9, 16'sd0, 1'b1);
    write_keep_count(5'd16);
    offer_point(-16'sd1, 16'sd0, 1'b1);
  endtask

  // k lowered while points are held: the next point cuts the store to the
  // new k in one go.
  task automatic test_lowered_keep();
    write_keep_count(5'd8);
    offer_point(16'sd10, 16'sd10, 1'b0);
    offer_point(16'sd1, 16'sd2, 1'b0);
    offer_point(-16'sd3, 16'sd3, 1'b0);
    offer_point(16'sd100, -16'sd100, 1'b0);
    offer_point(16'sd0, 16'sd1, 1'b0);
    offer_point(16'sd6, 16'sd6, 1'b0);
    write_keep_count(5'd2);
    offer_point(16'sd2, 16'sd2, 1'b1);
  endtask

  // Random sets under one idling pattern, with two settings of k.
  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input logic [KCFG_W-1:0] first_keep);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    write_keep_count(first_keep);
    run_random_sets(12);
    write_keep_count(KCFG_W'($urandom_range(31)));
    run_random_sets(12);
  endtask

  // The receiver holds off for a long stretch while short sets keep coming,
  // so the first flush backs up and the input channel has to stall.
  task automatic test_backpressure();
    int s;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_keep_count(5'd4);
    @(posedge clk);
    hold_left = 300;
    for (s = 0; s < 12; s++) begin
      offer_point(pick_coord(0), pick_coord(1), 1'b0);
      offer_point(pick_coord(1), pick_coord(0), 1'b0);
      offer_point(pick_coord(2), pick_coord(1), 1'b1);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_keep_limits();
    test_lowered_keep();
    test_random_traffic(20, 56, 5'd1);
    test_random_traffic(56, 20, 5'd16);
    test_random_traffic(0, 0, KCFG_W'($urandom_range(31)));
    test_backpressure();

    // Drain: the last set ends in a flush, so everything owed must arrive.
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (MAX_KEEP + 4) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS k_nearest_points_select_core");
    end else begin
      $display("FAIL k_nearest_points_select_core");
    end
    $finish;
  end

endmodule

`default_nettype wire
